// File: design/cfwis_pkg.sv
package cfwis_pkg;

   localparam int ID_W     = 16;
   localparam int HANDLE_W = 16;
   localparam int OP_W     = 2;
   localparam int COUNT_W  = 5;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_SEARCH = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic shift;   // every cell takes its upper neighbor's entry
      logic push;    // the cell at the fill position loads the request data
   } cell_cmd_type;

endpackage

// File: design/cfwis_ifs.sv
interface cfwis_req_if;
   logic                          valid;
   logic                          ready;
   logic [cfwis_pkg::OP_W-1:0]     op;
   logic [cfwis_pkg::ID_W-1:0]     entry_id;
   logic [cfwis_pkg::HANDLE_W-1:0] entry_handle;

   modport source (output valid, output op, output entry_id, output entry_handle,
                   input ready);
   modport sink   (input valid, input op, input entry_id, input entry_handle,
                   output ready);
endinterface

interface cfwis_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          ok;
   logic [cfwis_pkg::HANDLE_W-1:0] out_handle;
   logic [cfwis_pkg::ID_W-1:0]     out_id;
   logic [cfwis_pkg::COUNT_W-1:0]  count;
   logic                          is_empty;
   logic                          is_full;

   modport source (output valid, output ok, output out_handle, output out_id,
                   output count, output is_empty, output is_full, input ready);
   modport sink   (input valid, input ok, input out_handle, input out_id,
                   input count, input is_empty, input is_full, output ready);
endinterface

// File: design/cfwis_cell.sv
module cfwis_cell #(
   parameter int CIDX = 0,
   parameter int CW   = 5
) (
   input  logic                           clock,
   input  cfwis_pkg::cell_cmd_type        cmd,
   input  logic [CW-1:0]                  fill,
   input  logic [cfwis_pkg::ID_W-1:0]     push_id,
   input  logic [cfwis_pkg::HANDLE_W-1:0] push_handle,
   input  logic [cfwis_pkg::ID_W-1:0]     nxt_id,
   input  logic [cfwis_pkg::HANDLE_W-1:0] nxt_handle,
   output logic [cfwis_pkg::ID_W-1:0]     id,
   output logic [cfwis_pkg::HANDLE_W-1:0] handle
);

   logic [cfwis_pkg::ID_W-1:0]     id_ff,     id_in;
   logic [cfwis_pkg::HANDLE_W-1:0] handle_ff, handle_in;
   logic                           load;

   assign load = cmd.push && (fill == CW'(CIDX));

   always_comb begin
      id_in     = id_ff;
      handle_in = handle_ff;
      if (cmd.shift) begin
         id_in     = nxt_id;
         handle_in = nxt_handle;
      end else if (load) begin
         id_in     = push_id;
         handle_in = push_handle;
      end
   end

   always_ff @(posedge clock) begin
      id_ff     <= id_in;
      handle_ff <= handle_in;
   end

   assign id     = id_ff;
   assign handle = handle_ff;

endmodule

// File: design/cfwis_ctrl.sv
module cfwis_ctrl #(
   parameter int DEPTH = 16,
   parameter int CW    = 5
) (
   input  logic                           clock,
   input  logic                           reset,
   cfwis_req_if.sink                      req_if,
   cfwis_rsp_if.source                    rsp_if,
   input  logic [cfwis_pkg::ID_W-1:0]     head_id,
   input  logic [cfwis_pkg::HANDLE_W-1:0] head_handle,
   output cfwis_pkg::cell_cmd_type        cmd,
   output logic [CW-1:0]                  fill
);

   localparam int SW = $clog2(DEPTH);

   cfwis_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                  fill_ff,   fill_in;
   logic [SW-1:0]                  step_ff,   step_in;
   logic [cfwis_pkg::ID_W-1:0]     key_ff,    key_in;
   logic                           found_ff,  found_in;
   logic [cfwis_pkg::ID_W-1:0]     hit_id_ff, hit_id_in;
   logic [cfwis_pkg::HANDLE_W-1:0] hit_hnd_ff, hit_hnd_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           ok_ff,        ok_in;
   logic [cfwis_pkg::HANDLE_W-1:0] out_hnd_ff,   out_hnd_in;
   logic [cfwis_pkg::ID_W-1:0]     out_id_ff,    out_id_in;

   cfwis_pkg::op_type op;
   logic accept, is_push, is_pop, is_search, push_ok, pop_ok;
   logic last_step, hit;

   assign op        = cfwis_pkg::op_type'(req_if.op);
   assign accept    = req_if.valid && req_if.ready;
   assign is_push   = accept && (op == cfwis_pkg::OP_PUSH);
   assign is_pop    = accept && (op == cfwis_pkg::OP_POP);
   assign is_search = accept && (op == cfwis_pkg::OP_SEARCH);
   assign push_ok   = is_push && (fill_ff < CW'(DEPTH)) && (req_if.entry_handle != '0);
   assign pop_ok    = is_pop && (fill_ff != '0);
   assign last_step = (step_ff == SW'(DEPTH - 1));
   // the ring rotates once per cycle; cell 0 holds the entry 'step' places past the oldest
   assign hit       = (state_ff == cfwis_pkg::ST_SEARCH) && !found_ff &&
                      (CW'(step_ff) < fill_ff) && (head_id == key_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cfwis_pkg::ST_IDLE: begin
            if (is_search) state_in = cfwis_pkg::ST_SEARCH;
         end
         cfwis_pkg::ST_SEARCH: begin
            if (last_step) state_in = cfwis_pkg::ST_IDLE;
         end
         default: state_in = cfwis_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_if.ready = 1'b0;
      cmd.shift    = 1'b0;
      cmd.push     = 1'b0;
      case (state_ff)
         cfwis_pkg::ST_IDLE: begin
            req_if.ready = !rsp_valid_ff || rsp_if.ready;
            cmd.shift    = pop_ok;
            cmd.push     = push_ok;
         end
         cfwis_pkg::ST_SEARCH: begin
            cmd.shift = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      fill_in      = fill_ff;
      step_in      = step_ff;
      key_in       = key_ff;
      found_in     = found_ff;
      hit_id_in    = hit_id_ff;
      hit_hnd_in   = hit_hnd_ff;
      rsp_valid_in = rsp_valid_ff;
      ok_in        = ok_ff;
      out_hnd_in   = out_hnd_ff;
      out_id_in    = out_id_ff;

      if (rsp_valid_ff && rsp_if.ready) rsp_valid_in = 1'b0;

      if (push_ok) fill_in = fill_ff + CW'(1);
      if (pop_ok)  fill_in = fill_ff - CW'(1);

      if (is_search) begin
         step_in  = '0;
         key_in   = req_if.entry_id;
         found_in = 1'b0;
      end else if (accept) begin
         rsp_valid_in = 1'b1;
         ok_in        = push_ok || pop_ok;
         out_hnd_in   = pop_ok ? head_handle : '0;
         out_id_in    = pop_ok ? head_id : '0;
      end

      if (state_ff == cfwis_pkg::ST_SEARCH) begin
         step_in = step_ff + SW'(1);
         if (hit) begin
            found_in   = 1'b1;
            hit_id_in  = head_id;
            hit_hnd_in = head_handle;
         end
         if (last_step) begin
            rsp_valid_in = 1'b1;
            ok_in        = found_ff || hit;
            out_hnd_in   = hit ? head_handle : (found_ff ? hit_hnd_ff : '0);
            out_id_in    = hit ? head_id : (found_ff ? hit_id_ff : '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cfwis_pkg::ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      hit_id_ff  <= hit_id_in;
      hit_hnd_ff <= hit_hnd_in;
      ok_ff      <= ok_in;
      out_hnd_ff <= out_hnd_in;
      out_id_ff  <= out_id_in;
   end

   assign fill              = fill_ff;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.ok         = ok_ff;
   assign rsp_if.out_handle = out_hnd_ff;
   assign rsp_if.out_id     = out_id_ff;
   assign rsp_if.count      = cfwis_pkg::COUNT_W'(fill_ff);
   assign rsp_if.is_empty   = (fill_ff == '0);
   assign rsp_if.is_full    = (fill_ff == CW'(DEPTH));

endmodule

// File: design/circular_fifo_with_id_search_core.sv
// Push and pop: the result is registered and shows the cycle after the request is taken.
// Search: the ring of DEPTH cells rotates one place per cycle through the head compare,
//   so a search holds the block for a full turn and its result follows the last rotation.
// Throughput: one push or pop per cycle while results are taken; none during a search.
// Synchronous active-high reset empties the queue and drops any pending result;
// entry storage is not cleared.
module circular_fifo_with_id_search_core #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   cfwis_req_if.sink   req_if,
   cfwis_rsp_if.source rsp_if
);

   localparam int CW = $clog2(DEPTH + 1);

   cfwis_pkg::cell_cmd_type        cmd;
   logic [CW-1:0]                  fill;
   logic [cfwis_pkg::ID_W-1:0]     cell_id  [DEPTH];
   logic [cfwis_pkg::HANDLE_W-1:0] cell_hnd [DEPTH];

   cfwis_ctrl #(
      .DEPTH (DEPTH),
      .CW    (CW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .head_id     (cell_id[0]),
      .head_handle (cell_hnd[0]),
      .cmd         (cmd),
      .fill        (fill)
   );

   // cell 0 is the oldest entry; each cell takes from the next one up, the top wraps to 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cfwis_cell #(
         .CIDX (i),
         .CW   (CW)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .fill        (fill),
         .push_id     (req_if.entry_id),
         .push_handle (req_if.entry_handle),
         .nxt_id      (cell_id[(i + 1) % DEPTH]),
         .nxt_handle  (cell_hnd[(i + 1) % DEPTH]),
         .id          (cell_id[i]),
         .handle      (cell_hnd[i])
      );
   end

endmodule

// File: dv/circular_fifo_with_id_search_core_tb.sv
module circular_fifo_with_id_search_core_tb;

   localparam int DEPTH       = 16;
   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_REQS = 1200;
   localparam int LONG_HOLD   = 400;
   localparam int ID_W        = cfwis_pkg::ID_W;
   localparam int HANDLE_W    = cfwis_pkg::HANDLE_W;
   localparam int COUNT_W     = cfwis_pkg::COUNT_W;

   typedef struct {
      cfwis_pkg::op_type   op;
      logic [ID_W-1:0]     id;
      logic [HANDLE_W-1:0] handle;
      int unsigned         gap;
      bit                  drain_first;  // wait until every response is back
   } fifo_req_type;

   typedef struct packed {
      logic                ok;
      logic [HANDLE_W-1:0] handle;
      logic [ID_W-1:0]     id;
      logic [COUNT_W-1:0]  count;
      logic                is_empty;
      logic                is_full;
   } fifo_result_type;

   logic clock;
   logic reset;

   cfwis_req_if req_if ();
   cfwis_rsp_if rsp_if ();

   circular_fifo_with_id_search_core #(
      .DEPTH(DEPTH)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   fifo_req_type    pending_requests[$];
   fifo_result_type expected_results[$];
   int unsigned     error_count;
   int unsigned     cycle_count;

   // queue contents as the scoreboard sees them
   logic [HANDLE_W-1:0] ring_handle[DEPTH];
   logic [ID_W-1:0]     ring_id[DEPTH];
   int unsigned         ring_head;
   int unsigned         ring_tail;
   int unsigned         ring_fill;

   always #5 clock = ~clock;

   function automatic fifo_result_type fifo_predict(input fifo_req_type r);
      fifo_result_type res;
      int unsigned slot;
      res = '0;
      case (r.op)
         cfwis_pkg::OP_PUSH: begin
            if (ring_fill < DEPTH && r.handle != '0) begin
               ring_handle[ring_tail] = r.handle;
               ring_id[ring_tail] = r.id;
               ring_tail = (ring_tail + 1) % DEPTH;
               ring_fill++;
               res.ok = 1'b1;
            end
         end
         cfwis_pkg::OP_POP: begin
            if (ring_fill != 0) begin
               res.handle = ring_handle[ring_head];
               res.id = ring_id[ring_head];
               ring_head = (ring_head + 1) % DEPTH;
               ring_fill--;
               res.ok = 1'b1;
            end
         end
         cfwis_pkg::OP_SEARCH: begin
            slot = ring_head;
            for (int i = 0; i < ring_fill; i++) begin
               if (ring_id[slot] == r.id) begin
                  res.handle = ring_handle[slot];
                  res.id = ring_id[slot];
                  res.ok = 1'b1;
                  break;
               end
               slot = (slot + 1) % DEPTH;
            end
         end
         default: ;
      endcase
      res.count = COUNT_W'(ring_fill);
      res.is_empty = (ring_fill == 0);
      res.is_full = (ring_fill == DEPTH);
      return res;
   endfunction

   // mostly short, a few long
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   task automatic add_req(input cfwis_pkg::op_type op, input logic [ID_W-1:0] id,
                          input logic [HANDLE_W-1:0] handle, input int unsigned gap,
                          input bit drain_first);
      fifo_req_type r;
      r.op = op;
      r.id = id;
      r.handle = handle;
      r.gap = gap;
      r.drain_first = drain_first;
      pending_requests.push_back(r);
   endtask

   // request driver
   int unsigned  idle_left;
   fifo_req_type next_req;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         idle_left = 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (idle_left > 0) begin
            req_if.valid <= 1'b0;
            idle_left--;
         end else if (pending_requests.size() == 0) begin
            req_if.valid <= 1'b0;
         end else if (pending_requests[0].drain_first &&
                      (req_if.valid || expected_results.size() != 0)) begin
            req_if.valid <= 1'b0;
         end else begin
            next_req = pending_requests.pop_front();
            req_if.valid <= 1'b1;
            req_if.op <= next_req.op;
            req_if.entry_id <= next_req.id;
            req_if.entry_handle <= next_req.handle;
            if (pending_requests.size() != 0)
               idle_left = pending_requests[0].gap;
         end
      end
   end

   // response ready: random stalls, calm stretches, one long hold
   int unsigned hold_left;
   int unsigned mode_left;
   int unsigned rsp_taken;
   bit          calm;
   bit          long_hold_done;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left = 0;
         mode_left = 0;
         rsp_taken = 0;
         long_hold_done = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            rsp_taken++;
         if (mode_left == 0) begin
            mode_left = 50;
            calm = ($urandom_range(0, 9) < 3);
         end
         mode_left--;
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else if (!long_hold_done && rsp_taken >= 500) begin
            long_hold_done = 1;
            hold_left = LONG_HOLD;
            rsp_if.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            hold_left = idle_len();
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // predict on each accepted request, check each accepted response
   fifo_req_type    seen_req;
   fifo_result_type want;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            seen_req.op = cfwis_pkg::op_type'(req_if.op);
            seen_req.id = req_if.entry_id;
            seen_req.handle = req_if.entry_handle;
            expected_results.push_back(fifo_predict(seen_req));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t: response with no request pending, expected none, actual %0h",
                        $time, {rsp_if.ok, rsp_if.out_handle, rsp_if.out_id,
                                rsp_if.count, rsp_if.is_empty, rsp_if.is_full});
            end else begin
               want = expected_results.pop_front();
               check_field("ok", want.ok, rsp_if.ok);
               check_field("out_handle", want.handle, rsp_if.out_handle);
               check_field("out_id", want.id, rsp_if.out_id);
               check_field("count", want.count, rsp_if.count);
               check_field("is_empty", want.is_empty, rsp_if.is_empty);
               check_field("is_full", want.is_full, rsp_if.is_full);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   logic [ID_W-1:0]     id_pool[6];
   int unsigned         phase;
   bit                  quiet;
   int unsigned         r;
   cfwis_pkg::op_type   op;
   logic [ID_W-1:0]     key;
   logic [HANDLE_W-1:0] hnd;

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      cycle_count = 0;
      error_count = 0;
      ring_head = 0;
      ring_tail = 0;
      ring_fill = 0;
      req_if.valid = 1'b0;
      req_if.op = cfwis_pkg::OP_NONE;
      req_if.entry_id = '0;
      req_if.entry_handle = '0;
      rsp_if.ready = 1'b0;

      // empty-queue cases, zero handle, field extremes
      add_req(cfwis_pkg::OP_POP, 16'h0000, 16'h0000, 0, 0);
      add_req(cfwis_pkg::OP_SEARCH, 16'h0000, 16'h0000, 0, 0);
      add_req(cfwis_pkg::OP_NONE, 16'hFFFF, 16'hFFFF, 0, 0);
      add_req(cfwis_pkg::OP_PUSH, 16'h1234, 16'h0000, 0, 0);
      add_req(cfwis_pkg::OP_PUSH, 16'h0000, 16'hFFFF, 0, 0);
      add_req(cfwis_pkg::OP_PUSH, 16'hFFFF, 16'h0001, 0, 0);
      add_req(cfwis_pkg::OP_SEARCH, 16'hFFFF, 16'h0000, 0, 0);
      add_req(cfwis_pkg::OP_SEARCH, 16'h5555, 16'hAAAA, 0, 0);
      // fill up; duplicate ids so the search must return the oldest match
      for (int i = 0; i < DEPTH - 2; i++)
         add_req(cfwis_pkg::OP_PUSH, (i % 2) ? 16'hFFFF : ID_W'(16'h00A0 + i),
                 HANDLE_W'(16'h0100 + i), 0, 0);
      add_req(cfwis_pkg::OP_PUSH, 16'hAAAA, 16'hBEEF, 0, 0);
      add_req(cfwis_pkg::OP_SEARCH, 16'hFFFF, 16'h0000, 0, 0);
      add_req(cfwis_pkg::OP_NONE, 16'h0000, 16'h0000, 0, 0);
      add_req(cfwis_pkg::OP_POP, 16'h0000, 16'h0000, 0, 0);

      id_pool[0] = 16'h0000;
      id_pool[1] = 16'hFFFF;
      for (int i = 2; i < 6; i++)
         id_pool[i] = ID_W'($urandom_range(0, 16'hFFFF));

      // phases of 40 requests: filling, draining or mixed
      for (int n = 0; n < RANDOM_REQS; n++) begin
         if (n % 40 == 0) begin
            phase = $urandom_range(0, 2);
            quiet = ($urandom_range(0, 3) == 0);
         end
         r = $urandom_range(0, 99);
         case (phase)
            0: op = (r < 70) ? cfwis_pkg::OP_PUSH : (r < 82) ? cfwis_pkg::OP_POP :
                    (r < 97) ? cfwis_pkg::OP_SEARCH : cfwis_pkg::OP_NONE;
            1: op = (r < 12) ? cfwis_pkg::OP_PUSH : (r < 82) ? cfwis_pkg::OP_POP :
                    (r < 97) ? cfwis_pkg::OP_SEARCH : cfwis_pkg::OP_NONE;
            default: op = (r < 40) ? cfwis_pkg::OP_PUSH : (r < 70) ? cfwis_pkg::OP_POP :
                          (r < 97) ? cfwis_pkg::OP_SEARCH : cfwis_pkg::OP_NONE;
         endcase
         key = ($urandom_range(0, 9) < 7) ? id_pool[$urandom_range(0, 5)]
                                           : ID_W'($urandom_range(0, 16'hFFFF));
         hnd = ($urandom_range(0, 19) == 0) ? '0 : HANDLE_W'($urandom_range(1, 16'hFFFF));
         add_req(op, key, hnd, quiet ? 0 : idle_len(),
                 (n == 0) || ($urandom_range(0, 99) == 0));
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_if.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (2 * DEPTH + 4) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
